// File: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a condition on every clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/repc_pkg.sv
`default_nettype none

package repc_pkg;

  localparam int COORD_W = 12;
  localparam int DIM_W   = 13;
  localparam int ORG_W   = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  localparam int DEF_PIXEL_COLS = 1024;
  localparam int DEF_PIXEL_ROWS = 1024;

  localparam logic [CFG_IDX_W-1:0] CFG_SHAPE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STYLE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORG_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORG_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STROKE = 3'd6;

  localparam logic SHAPE_RECT    = 1'b0;
  localparam logic SHAPE_ELLIPSE = 1'b1;

  localparam logic [1:0] STYLE_OUTLINE = 2'd0;
  localparam logic [1:0] STYLE_FILL    = 2'd1;

  localparam logic [1:0] PAINT_NONE   = 2'd0;
  localparam logic [1:0] PAINT_STROKE = 2'd1;
  localparam logic [1:0] PAINT_FILL   = 2'd2;

  typedef struct packed {
    logic                    shape_kind;
    logic [1:0]              style;
    logic signed [ORG_W-1:0] org_x;
    logic signed [ORG_W-1:0] org_y;
    logic [DIM_W-1:0]        obj_width;
    logic [DIM_W-1:0]        obj_height;
    logic [7:0]              stroke;
  } repc_cfg_t;

endpackage

`default_nettype wire

// File: design/rect_ellipse_pixel_coverage.sv
// Classifies one pixel per beat against a configured rectangle or ellipse and returns the
// echoed coordinate with a paint code (none, stroke or fill). A new pixel can be accepted
// every clock while the output is not stalled. A beat passes five register stages
// (offsets, box test, squares, cross products, compare) before its result is valid; the
// squares and cross products are the two multiplier stages of the exact ellipse test. A
// stalled output fills empty stages first, so input keeps flowing until the pipeline is
// full. Write configuration only while no beat is in flight.

`default_nettype none

module rect_ellipse_pixel_coverage #(
  parameter int PIXEL_COLS = repc_pkg::DEF_PIXEL_COLS,
  parameter int PIXEL_ROWS = repc_pkg::DEF_PIXEL_ROWS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [repc_pkg::COORD_W-1:0]    pixel_x,
  input  wire logic [repc_pkg::COORD_W-1:0]    pixel_y,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [repc_pkg::COORD_W-1:0]         out_x,
  output logic [repc_pkg::COORD_W-1:0]         out_y,
  output logic [1:0]                           paint,
  input  wire logic                            cfg_we,
  input  wire logic [repc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [repc_pkg::CFG_DATA_W-1:0] cfg_data
);

  import repc_pkg::*;

  repc_cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shape_kind <= SHAPE_RECT;
      cfg.style <= STYLE_OUTLINE;
      cfg.org_x <= '0;
      cfg.org_y <= '0;
      cfg.obj_width <= '0;
      cfg.obj_height <= '0;
      cfg.stroke <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SHAPE:  cfg.shape_kind <= cfg_data[0];
        CFG_STYLE:  cfg.style <= cfg_data[1:0];
        CFG_ORG_X:  cfg.org_x <= $signed(cfg_data[ORG_W-1:0]);
        CFG_ORG_Y:  cfg.org_y <= $signed(cfg_data[ORG_W-1:0]);
        CFG_WIDTH:  cfg.obj_width <= cfg_data[DIM_W-1:0];
        CFG_HEIGHT: cfg.obj_height <= cfg_data[DIM_W-1:0];
        CFG_STROKE: cfg.stroke <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  repc_pipe #(
    .PIXEL_COLS (PIXEL_COLS),
    .PIXEL_ROWS (PIXEL_ROWS)
  ) u_pipe (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (out_x),
    .out_y     (out_y),
    .paint     (paint)
  );

endmodule

`default_nettype wire

// File: design/repc_pipe.sv
`default_nettype none

module repc_pipe #(
  parameter int PIXEL_COLS = repc_pkg::DEF_PIXEL_COLS,
  parameter int PIXEL_ROWS = repc_pkg::DEF_PIXEL_ROWS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire repc_pkg::repc_cfg_t           cfg,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [repc_pkg::COORD_W-1:0]  pixel_x,
  input  wire logic [repc_pkg::COORD_W-1:0]  pixel_y,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [repc_pkg::COORD_W-1:0]       out_x,
  output logic [repc_pkg::COORD_W-1:0]       out_y,
  output logic [1:0]                         paint
);

  import repc_pkg::*;

  localparam int DX_W = ORG_W + 1;
  localparam int SQ_W = 2 * DIM_W;
  localparam int PR_W = 2 * SQ_W;

  logic [5:1] v;
  logic [5:1] ld;

  // stage 1
  logic [COORD_W-1:0]     x1, y1;
  logic signed [DX_W-1:0] dx1, dy1;
  logic                   rast1;
  // stage 2
  logic [COORD_W-1:0] x2, y2;
  logic               inbox2, rect_ol2;
  logic [DIM_W-1:0]   aa2, ab2;
  // stage 3
  logic [COORD_W-1:0] x3, y3;
  logic               inbox3, rect_ol3, thin3;
  logic [SQ_W-1:0]    a2sq, b2sq, w2sq, h2sq, km3, mm3;
  // stage 4
  logic [COORD_W-1:0] x4, y4;
  logic               inbox4, rect_ol4, thin4;
  logic [PR_W-1:0]    p1, p2, whole4, thr4;

  logic [7:0]        s_eff;
  logic [8:0]        s_dbl;
  logic [DIM_W-1:0]  w, h, m_dim, big_dim;
  logic              fill_en, line_en;

  logic              in_x, in_y;
  logic [DIM_W-1:0]  dxu, dyu, rx, ry, ring_a, ring_b, ring;
  logic [DIM_W:0]    ta, tb;

  logic [PR_W:0]     sum;
  logic              in_ell, ell_ol, on_fill, on_ol;
  logic [1:0]        paint_next;

  assign w = cfg.obj_width;
  assign h = cfg.obj_height;
  assign s_eff = (cfg.stroke == 8'd0) ? 8'd1 : cfg.stroke;
  assign s_dbl = {s_eff, 1'b0};
  assign m_dim = (w < h) ? w : h;
  assign big_dim = (w < h) ? h : w;
  assign fill_en = (cfg.style != STYLE_OUTLINE);
  assign line_en = (cfg.style != STYLE_FILL);

  always_comb begin
    ld[5] = !v[5] || out_ready;
    for (int i = 4; i >= 1; i--) begin
      ld[i] = !v[i] || ld[i+1];
    end
  end

  assign in_ready = ld[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ld[1]) v[1] <= in_valid;
      for (int i = 2; i <= 5; i++) begin
        if (ld[i]) v[i] <= v[i-1];
      end
    end
  end

  // stage 1: offsets from the box corner
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      x1 <= pixel_x;
      y1 <= pixel_y;
      dx1 <= $signed({{(DX_W-COORD_W){1'b0}}, pixel_x}) -
             $signed({cfg.org_x[ORG_W-1], cfg.org_x});
      dy1 <= $signed({{(DX_W-COORD_W){1'b0}}, pixel_y}) -
             $signed({cfg.org_y[ORG_W-1], cfg.org_y});
      rast1 <= ({1'b0, pixel_x} < (COORD_W+1)'(PIXEL_COLS)) &&
               ({1'b0, pixel_y} < (COORD_W+1)'(PIXEL_ROWS));
    end
  end

  // stage 2: box test, rectangle ring, centered ellipse offsets
  always_comb begin
    in_x = !dx1[DX_W-1] && (dx1 < $signed({{(DX_W-DIM_W){1'b0}}, w}));
    in_y = !dy1[DX_W-1] && (dy1 < $signed({{(DX_W-DIM_W){1'b0}}, h}));
    dxu = dx1[DIM_W-1:0];
    dyu = dy1[DIM_W-1:0];
    rx = w - DIM_W'(1) - dxu;
    ry = h - DIM_W'(1) - dyu;
    ring_a = (rx < dxu) ? rx : dxu;
    ring_b = (ry < dyu) ? ry : dyu;
    ring = (ring_b < ring_a) ? ring_b : ring_a;
    ta = {dxu, 1'b1} - {1'b0, w};
    tb = {dyu, 1'b1} - {1'b0, h};
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      x2 <= x1;
      y2 <= y1;
      inbox2 <= rast1 && in_x && in_y;
      rect_ol2 <= ring < {{(DIM_W-8){1'b0}}, s_eff};
      aa2 <= ta[DIM_W] ? DIM_W'(-ta) : ta[DIM_W-1:0];
      ab2 <= tb[DIM_W] ? DIM_W'(-tb) : tb[DIM_W-1:0];
    end
  end

  // stage 3: squares
  always_ff @(posedge clk) begin
    if (ld[3]) begin
      x3 <= x2;
      y3 <= y2;
      inbox3 <= inbox2;
      rect_ol3 <= rect_ol2;
      thin3 <= (m_dim < DIM_W'(3)) || ({{(DIM_W-9){1'b0}}, s_dbl} >= m_dim);
      a2sq <= aa2 * aa2;
      b2sq <= ab2 * ab2;
      w2sq <= w * w;
      h2sq <= h * h;
      km3 <= (m_dim - {{(DIM_W-9){1'b0}}, s_dbl}) * m_dim;
      mm3 <= big_dim * big_dim;
    end
  end

  // stage 4: cross products
  always_ff @(posedge clk) begin
    if (ld[4]) begin
      x4 <= x3;
      y4 <= y3;
      inbox4 <= inbox3;
      rect_ol4 <= rect_ol3;
      thin4 <= thin3;
      p1 <= a2sq * h2sq;
      p2 <= b2sq * w2sq;
      whole4 <= w2sq * h2sq;
      thr4 <= km3 * mm3;
    end
  end

  // stage 5: compare and classify
  always_comb begin
    sum = {1'b0, p1} + {1'b0, p2};
    in_ell = sum <= {1'b0, whole4};
    ell_ol = in_ell && (thin4 || (sum >= {1'b0, thr4}));
    on_fill = (cfg.shape_kind == SHAPE_RECT) ? 1'b1 : in_ell;
    on_ol = (cfg.shape_kind == SHAPE_RECT) ? rect_ol4 : ell_ol;
    if (!inbox4) begin
      paint_next = PAINT_NONE;
    end else if (line_en && on_ol) begin
      paint_next = PAINT_STROKE;
    end else if (fill_en && on_fill) begin
      paint_next = PAINT_FILL;
    end else begin
      paint_next = PAINT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      out_x <= x4;
      out_y <= y4;
      paint <= paint_next;
    end
  end

  assign out_valid = v[5];

`include "assert_macros.svh"

  `ASSERT_IMPLY(a_paint_code, out_valid, paint <= PAINT_FILL, "paint code out of range")
  `ASSERT_IMPLY(a_outside_none, v[4] && !inbox4, paint_next == PAINT_NONE, "pixel outside box painted")
  `ASSERT_NEXT(a_enter, in_valid && in_ready, v[1], "accepted beat lost at entry")
  `ASSERT_NEXT(a_reach_out, v[4] && ld[5], out_valid, "beat lost before output")

endmodule

`default_nettype wire
